// File: design/mfc_pkg.sv
// Shared constants, opcodes and control/status types for the motor frame codec.
`default_nettype none

package mfc_pkg;

    // Exchange kinds carried in the input tuser.
    localparam logic [1:0] KIND_TORQUE  = 2'd0;
    localparam logic [1:0] KIND_ENCODER = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Command opcodes sent to the motor.
    localparam logic [7:0] OP_NONE    = 8'h00;
    localparam logic [7:0] OP_TORQUE  = 8'hA1;
    localparam logic [7:0] OP_ENCODER = 8'h90;
    localparam logic [7:0] OP_STATUS  = 8'h9A;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AXIS_NEGATIVE  = 3'd0;
    localparam logic [2:0] CFG_TORQUE_GAIN    = 3'd1;
    localparam logic [2:0] CFG_TORQUE_INV     = 3'd2;
    localparam logic [2:0] CFG_POSITION_SCALE = 3'd3;
    localparam logic [2:0] CFG_POSITION_OFS   = 3'd4;
    localparam logic [2:0] CFG_VELOCITY_SCALE = 3'd5;

    // Register reset values.
    localparam logic        RST_AXIS_NEGATIVE  = 1'b0;
    localparam logic [15:0] RST_TORQUE_GAIN    = 16'd7655;
    localparam logic [15:0] RST_TORQUE_INV     = 16'd2192;
    localparam logic [31:0] RST_POSITION_SCALE = 32'd45756;
    localparam logic [31:0] RST_POSITION_OFS   = 32'd0;
    localparam logic [23:0] RST_VELOCITY_SCALE = 24'd32536;

    // Multiturn unwrap thresholds.
    localparam logic [15:0]        ENC_LOW_MARK   = 16'd10000;
    localparam logic [15:0]        ENC_HIGH_MARK  = 16'd50000;
    localparam logic [15:0]        ENC_RESET      = 16'd35000;
    localparam logic signed [15:0] TURN_CEILING   = 16'sd32767;
    localparam logic signed [15:0] TURN_FLOOR     = -16'sd32767;

    // Stream widths.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 176;

    typedef struct packed {
        logic capture;
        logic unwrap;
        logic count;
        logic mul;
        logic round;
        logic load;
    } mfc_cmd_t;

    typedef struct packed {
        logic out_free;
    } mfc_sts_t;

endpackage

`default_nettype wire

// File: design/mfc_ctrl.sv
// Controller state machine sequencing one exchange through the datapath.
`default_nettype none

module mfc_ctrl
    import mfc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output mfc_cmd_t      cmd,
    input  wire mfc_sts_t sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UNWRAP = 3'd1;
    localparam logic [2:0] ST_COUNT  = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_ROUND  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_UNWRAP;
                end
            end
            ST_UNWRAP:
            begin
                cmd.unwrap = 1'b1;
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait here until the output register can take the result.
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("more than one datapath command in a cycle");
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> sts.out_free)
        else $error("result loaded while output register is occupied");
    a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.unwrap)
        else $error("accepted item did not enter the unwrap step");
    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !sts.out_free) |=> state_reg == ST_FINISH)
        else $error("finished result dropped while output stalled");
`endif

endmodule

`default_nettype wire

// File: design/mfc_dp.sv
// Datapath: configuration registers, multiturn unwrap, scaling and output register.
`default_nettype none

module mfc_dp
    import mfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mfc_cmd_t              cmd,
    output mfc_sts_t                   sts,
    input  wire logic [1:0]            s_tuser,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [7:0]                 m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);

    localparam logic signed [51:0] POS_MAX = 52'sd2147483647;
    localparam logic signed [51:0] POS_MIN = -52'sd2147483648;

    function automatic logic [15:0] sat16(input logic neg, input logic [24:0] mag);
        logic [15:0] r;
        if (neg)
        begin
            r = (mag > 25'd32768) ? 16'h8000 : 16'(25'd0 - mag);
        end
        else
        begin
            r = (mag > 25'd32767) ? 16'h7FFF : mag[15:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic neg, input logic [32:0] mag);
        logic [31:0] r;
        if (neg)
        begin
            r = (mag > 33'd2147483648) ? 32'h8000_0000 : 32'(33'd0 - mag);
        end
        else
        begin
            r = (mag > 33'd2147483647) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic        axis_negative_reg;
    logic [15:0] torque_gain_reg;
    logic [15:0] torque_inv_reg;
    logic [31:0] position_scale_reg;
    logic [31:0] position_ofs_reg;
    logic [23:0] velocity_scale_reg;

    // Multiturn state.
    logic [15:0] last_encoder_reg;
    logic [15:0] turn_count_reg;

    // Captured item.
    logic [1:0]  kind_reg;
    logic [15:0] tq_reg;
    logic [7:0]  b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg, b7_reg;

    // Pipeline of the arithmetic.
    logic [15:0] enc_reg;
    logic        tq_neg_reg, rt_neg_reg, rv_neg_reg, count_neg_reg;
    logic [15:0] tq_mag_reg, rt_mag_reg, rv_mag_reg;
    logic [31:0] count_mag_reg;
    logic [31:0] cur_prod_reg, tqd_prod_reg;
    logic [39:0] vel_prod_reg;
    logic [63:0] pos_prod_reg;
    logic [16:0] cur_q_reg;
    logic [24:0] tqd_q_reg;
    logic [32:0] vel_q_reg;
    logic [48:0] pos_q_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [7:0]           m_tuser_reg;

    assign cfg_ready    = 1'b1;
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_negative_reg  <= RST_AXIS_NEGATIVE;
            torque_gain_reg    <= RST_TORQUE_GAIN;
            torque_inv_reg     <= RST_TORQUE_INV;
            position_scale_reg <= RST_POSITION_SCALE;
            position_ofs_reg   <= RST_POSITION_OFS;
            velocity_scale_reg <= RST_VELOCITY_SCALE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_AXIS_NEGATIVE:  axis_negative_reg  <= cfg_data[0];
                CFG_TORQUE_GAIN:    torque_gain_reg    <= cfg_data[15:0];
                CFG_TORQUE_INV:     torque_inv_reg     <= cfg_data[15:0];
                CFG_POSITION_SCALE: position_scale_reg <= cfg_data;
                CFG_POSITION_OFS:   position_ofs_reg   <= cfg_data;
                CFG_VELOCITY_SCALE: velocity_scale_reg <= cfg_data[23:0];
                default:            ;
            endcase
        end
    end

    // Capture of an accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= s_tuser;
            tq_reg   <= s_tdata[15:0];
            b1_reg   <= s_tdata[23:16];
            b2_reg   <= s_tdata[31:24];
            b3_reg   <= s_tdata[39:32];
            b4_reg   <= s_tdata[47:40];
            b5_reg   <= s_tdata[55:48];
            b6_reg   <= s_tdata[63:56];
            b7_reg   <= s_tdata[71:64];
        end
    end

    // Unwrap step: torque exchanges carry the encoder in bytes 6-7,
    // encoder replies in bytes 2-3.
    logic [15:0] enc_word;
    logic        enc_present;

    always_comb
    begin
        enc_word    = (kind_reg == KIND_TORQUE) ? {b7_reg, b6_reg} : {b3_reg, b2_reg};
        enc_present = (kind_reg == KIND_TORQUE) || (kind_reg == KIND_ENCODER);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_encoder_reg <= ENC_RESET;
            turn_count_reg   <= '0;
        end
        else if (cmd.unwrap && enc_present)
        begin
            if (enc_word < ENC_LOW_MARK && last_encoder_reg > ENC_HIGH_MARK)
            begin
                if ($signed(turn_count_reg) < TURN_CEILING)
                begin
                    turn_count_reg <= turn_count_reg + 16'd1;
                end
            end
            else if (enc_word > ENC_HIGH_MARK && last_encoder_reg < ENC_LOW_MARK)
            begin
                if ($signed(turn_count_reg) > TURN_FLOOR)
                begin
                    turn_count_reg <= turn_count_reg - 16'd1;
                end
            end
            last_encoder_reg <= enc_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.unwrap)
        begin
            enc_reg <= enc_word;
        end
    end

    // Count step: signs and magnitudes of every multiplicand.
    logic [15:0] turn_abs;
    logic [31:0] span;
    logic [15:0] rt_word, rv_word;

    always_comb
    begin
        turn_abs = turn_count_reg[15] ? (16'd0 - turn_count_reg) : turn_count_reg;
        // 65535 * |turns|
        span     = {turn_abs, 16'd0} - {16'd0, turn_abs};
        rt_word  = {b3_reg, b2_reg};
        rv_word  = {b5_reg, b4_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.count)
        begin
            // With negative turns the count is never positive, since the
            // encoder word never exceeds one span.
            count_neg_reg <= turn_count_reg[15];
            count_mag_reg <= turn_count_reg[15] ? (span - {16'd0, enc_reg})
                                                : (span + {16'd0, enc_reg});
            tq_neg_reg    <= tq_reg[15];
            tq_mag_reg    <= tq_reg[15] ? (16'd0 - tq_reg) : tq_reg;
            rt_neg_reg    <= rt_word[15];
            rt_mag_reg    <= rt_word[15] ? (16'd0 - rt_word) : rt_word;
            rv_neg_reg    <= rv_word[15];
            rv_mag_reg    <= rv_word[15] ? (16'd0 - rv_word) : rv_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            cur_prod_reg <= 32'(tq_mag_reg) * 32'(torque_gain_reg);
            tqd_prod_reg <= 32'(rt_mag_reg) * 32'(torque_inv_reg);
            vel_prod_reg <= 40'(rv_mag_reg) * 40'(velocity_scale_reg);
            pos_prod_reg <= 64'(count_mag_reg) * 64'(position_scale_reg);
        end
    end

    // Round step: halves round away from zero on the magnitude.
    logic [32:0] cur_sum, tqd_sum;
    logic [40:0] vel_sum;
    logic [64:0] pos_sum;

    always_comb
    begin
        cur_sum = 33'(cur_prod_reg) + 33'h8000;
        tqd_sum = 33'(tqd_prod_reg) + 33'd128;
        vel_sum = 41'(vel_prod_reg) + 41'd128;
        pos_sum = 65'(pos_prod_reg) + 65'h8000;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            cur_q_reg <= cur_sum[32:16];
            tqd_q_reg <= tqd_sum[32:8];
            vel_q_reg <= vel_sum[40:8];
            pos_q_reg <= pos_sum[64:16];
        end
    end

    // Finish step: sign, offset, saturation and field selection.
    logic [15:0] cur_val, tqd_val;
    logic [31:0] vel_val, pos_val;
    logic [50:0] ofs_ext, pos_q_ext, pos_off;
    logic [51:0] pos_fin;
    logic [7:0]  opcode;
    logic [15:0] f_current, f_torque, f_raw, f_ofs, f_volt;
    logic [31:0] f_vel, f_pos;
    logic [7:0]  f_temp, f_err;

    always_comb
    begin
        cur_val   = sat16(tq_neg_reg ^ axis_negative_reg, {8'd0, cur_q_reg});
        tqd_val   = sat16(rt_neg_reg ^ axis_negative_reg, tqd_q_reg);
        vel_val   = sat32(rv_neg_reg ^ axis_negative_reg, vel_q_reg);

        ofs_ext   = {{19{position_ofs_reg[31]}}, position_ofs_reg};
        pos_q_ext = {2'b00, pos_q_reg};
        pos_off   = count_neg_reg ? (ofs_ext - pos_q_ext) : (ofs_ext + pos_q_ext);
        pos_fin   = axis_negative_reg ? (52'd0 - {pos_off[50], pos_off})
                                      : {pos_off[50], pos_off};
        if ($signed(pos_fin) > POS_MAX)
        begin
            pos_val = 32'h7FFF_FFFF;
        end
        else if ($signed(pos_fin) < POS_MIN)
        begin
            pos_val = 32'h8000_0000;
        end
        else
        begin
            pos_val = pos_fin[31:0];
        end

        opcode    = OP_NONE;
        f_current = '0;
        f_temp    = '0;
        f_torque  = '0;
        f_vel     = '0;
        f_pos     = '0;
        f_raw     = '0;
        f_ofs     = '0;
        f_volt    = '0;
        f_err     = '0;
        unique case (kind_reg)
            KIND_TORQUE:
            begin
                opcode    = OP_TORQUE;
                f_current = cur_val;
                f_temp    = b1_reg;
                f_torque  = tqd_val;
                f_vel     = vel_val;
                f_pos     = pos_val;
            end
            KIND_ENCODER:
            begin
                opcode    = OP_ENCODER;
                f_pos     = pos_val;
                f_raw     = {b5_reg, b4_reg};
                f_ofs     = {b7_reg, b6_reg};
            end
            KIND_STATUS:
            begin
                opcode    = OP_STATUS;
                f_temp    = b1_reg;
                f_volt    = {b4_reg, b3_reg};
                f_err     = b7_reg;
            end
            default:
            begin
                opcode    = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_tuser_reg <= opcode;
            m_tdata_reg <= {turn_count_reg, f_err, f_volt, f_ofs, f_raw,
                            f_pos, f_vel, f_torque, f_temp, f_current};
        end
    end

`ifndef SYNTHESIS
    a_turn_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        turn_count_reg != 16'h8000)
        else $error("turn count left its saturation range");
    a_turn_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.unwrap) |-> $stable(turn_count_reg))
        else $error("turn count changed outside the unwrap step");
`endif

endmodule

`default_nettype wire

// File: design/motor_frame_codec_multiturn.sv
// Motor frame codec with multiturn encoder unwrap: top level.
// The controller walks one item at a time through the unwrap, count, multiply, round and
// finish steps of a single datapath, and takes a new item only after the last is loaded
// into the output register; the finish step waits while that register is occupied.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst_n, asynchronous, active low) restores the register defaults and the unwrap state.
`default_nettype none

module motor_frame_codec_multiturn
    import mfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // desired_torque, reply_byte1 .. reply_byte7
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // kind
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // command_current, temperature, joint_torque, joint_velocity, joint_position,
    // raw_encoder, encoder_offset, supply_voltage, error_code, turns
    output logic [M_TDATA_W-1:0]       m_tdata,
    // command_opcode
    output logic [7:0]                 m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);

    mfc_cmd_t cmd;
    mfc_sts_t sts;

    mfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mfc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
